[rtl/core/ffba_pkg.sv]
// package for the first-fit block allocator core
// holds sizes, codes, table entry layout and the controller/datapath link structs
// no dependencies
package ffba_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int DATA_W      = 32;

    localparam int CFG_IDX_W   = 2;
    localparam int S_TDATA_W   = 64;
    localparam int S_TUSER_W   = 1;
    localparam int M_TDATA_W   = 32;
    localparam int M_TUSER_W   = 2;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [1:0] ST_TABLE_FULL = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND  = 2'd3;

    localparam logic [1:0] WR_HIT   = 2'd0;
    localparam logic [1:0] WR_SPLIT = 2'd1;
    localparam logic [1:0] WR_FREE  = 2'd2;
    localparam logic [1:0] WR_BUMP  = 2'd3;

    localparam logic [1:0] RES_ZERO = 2'd0;
    localparam logic [1:0] RES_HIT  = 2'd1;
    localparam logic [1:0] RES_BUMP = 2'd2;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] length;
        logic [DATA_W-1:0] start;
    } entry_t;

    typedef struct packed {
        logic       load_req;
        logic       scan_clear;
        logic       scan_run;
        logic       wr_en;
        logic [1:0] wr_op;
        logic       res_load;
        logic [1:0] res_status;
        logic [1:0] res_sel;
        logic       out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic is_free;
        logic size_zero;
        logic table_full;
        logic count_zero;
        logic hit;
        logic miss;
        logic fits;
        logic spare_nz;
        logic out_free;
    } dp_sts_t;

endpackage

[rtl/core/ffba_ctrl.sv]
// controller state machine of the first-fit block allocator
// sequences check, table scan, write-back and result hand-off
// depends on ffba_pkg
module ffba_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  ffba_pkg::dp_sts_t sts,
    output ffba_pkg::dp_cmd_t cmd
);
    import ffba_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_HIT   = 3'd3;
    localparam logic [2:0] S_SPLIT = 3'd4;
    localparam logic [2:0] S_FREE  = 3'd5;
    localparam logic [2:0] S_BUMP  = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_req = 1'b1;
                    state_next   = S_CHECK;
                end
            end
            S_CHECK: begin
                if (sts.is_free) begin
                    if (sts.count_zero) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        cmd.res_sel    = RES_ZERO;
                        state_next     = S_DONE;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end else begin
                    priority if (sts.size_zero) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NO_SPACE;
                        cmd.res_sel    = RES_ZERO;
                        state_next     = S_DONE;
                    end else if (sts.table_full) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_TABLE_FULL;
                        cmd.res_sel    = RES_ZERO;
                        state_next     = S_DONE;
                    end else if (sts.count_zero) begin
                        state_next = S_BUMP;
                    end else begin
                        cmd.scan_clear = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.hit) begin
                    state_next = sts.is_free ? S_FREE : S_HIT;
                end else if (sts.miss) begin
                    if (sts.is_free) begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_NOT_FOUND;
                        cmd.res_sel    = RES_ZERO;
                        state_next     = S_DONE;
                    end else begin
                        state_next = S_BUMP;
                    end
                end
            end
            S_HIT: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_op      = WR_HIT;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_sel    = RES_HIT;
                state_next     = sts.spare_nz ? S_SPLIT : S_DONE;
            end
            S_SPLIT: begin
                cmd.wr_en  = 1'b1;
                cmd.wr_op  = WR_SPLIT;
                state_next = S_DONE;
            end
            S_FREE: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_op      = WR_FREE;
                cmd.res_load   = 1'b1;
                cmd.res_status = ST_OK;
                cmd.res_sel    = RES_ZERO;
                state_next     = S_DONE;
            end
            S_BUMP: begin
                cmd.res_load = 1'b1;
                if (sts.fits) begin
                    cmd.wr_en      = 1'b1;
                    cmd.wr_op      = WR_BUMP;
                    cmd.res_status = ST_OK;
                    cmd.res_sel    = RES_BUMP;
                end else begin
                    cmd.res_status = ST_NO_SPACE;
                    cmd.res_sel    = RES_ZERO;
                end
                state_next = S_DONE;
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/ffba_dp.sv]
// datapath of the first-fit block allocator
// holds config, bump pointer, entry table memory, scan pipeline and output register
// depends on ffba_pkg
module ffba_dp (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffba_pkg::DATA_W-1:0]      cfg_data,
    input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [ffba_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic [ffba_pkg::M_TUSER_W-1:0]   m_tuser,
    input  ffba_pkg::dp_cmd_t                cmd,
    output ffba_pkg::dp_sts_t                sts
);
    import ffba_pkg::*;

    entry_t mem [TABLE_DEPTH];

    logic [DATA_W-1:0] heap_base_reg;
    logic [DATA_W-1:0] heap_size_reg;
    logic [DATA_W-1:0] bump_reg;
    logic [CNT_W-1:0]  count_reg;

    logic              req_cmd_reg;
    logic [DATA_W-1:0] req_size_reg;
    logic [DATA_W-1:0] req_addr_reg;

    logic [CNT_W-1:0]  rd_idx_reg;
    logic              rd_valid_reg;
    logic              rd_valid_next;
    logic [IDX_W-1:0]  chk_idx_reg;
    entry_t            rd_data_reg;

    logic [IDX_W-1:0]  hit_idx_reg;
    logic [DATA_W-1:0] hit_start_reg;
    logic [DATA_W-1:0] hit_len_reg;

    logic [1:0]        res_status_reg;
    logic [DATA_W-1:0] res_addr_reg;
    logic [DATA_W-1:0] res_addr_next;

    logic              m_tvalid_reg;
    logic [DATA_W-1:0] m_addr_reg;
    logic [1:0]        m_status_reg;

    logic              hit;
    logic              last_entry;
    logic [DATA_W:0]   limit_sum;
    logic [DATA_W:0]   limit_cap;
    logic [DATA_W:0]   bump_end;
    logic [IDX_W-1:0]  wr_addr;
    entry_t            wr_data;

    // configuration and bump pointer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            heap_size_reg <= '0;
            bump_reg      <= '0;
        end else begin
            if (cfg_valid && cfg_index == REG_HEAP_BASE) begin
                heap_base_reg <= cfg_data;
                bump_reg      <= cfg_data;
            end else if (cmd.wr_en && cmd.wr_op == WR_BUMP) begin
                bump_reg <= bump_reg + req_size_reg;
            end
            if (cfg_valid && cfg_index == REG_HEAP_SIZE) begin
                heap_size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.wr_en && (cmd.wr_op == WR_SPLIT || cmd.wr_op == WR_BUMP)) begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // request capture
    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            req_cmd_reg  <= s_tuser[0];
            req_size_reg <= s_tdata[DATA_W-1:0];
            req_addr_reg <= s_tdata[2*DATA_W-1:DATA_W];
        end
    end

    // table scan, one read per cycle, compare on the registered read in the next cycle
    assign rd_valid_next = cmd.scan_run && (rd_idx_reg < count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else if (cmd.scan_clear) begin
            rd_idx_reg   <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= rd_valid_next;
            if (rd_valid_next) begin
                rd_idx_reg <= rd_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_valid_next) begin
            chk_idx_reg <= rd_idx_reg[IDX_W-1:0];
        end
    end

    assign hit = rd_valid_reg && ((req_cmd_reg == CMD_FREE)
        ? (rd_data_reg.start == req_addr_reg)
        : (!rd_data_reg.busy && rd_data_reg.length >= req_size_reg));

    assign last_entry = (CNT_W'(chk_idx_reg) == CNT_W'(count_reg - 1'b1));

    always_ff @(posedge aclk) begin
        if (cmd.scan_run && hit) begin
            hit_idx_reg   <= chk_idx_reg;
            hit_start_reg <= rd_data_reg.start;
            hit_len_reg   <= rd_data_reg.length;
        end
    end

    // write-back
    always_comb begin
        wr_addr = hit_idx_reg;
        wr_data = '0;
        unique case (cmd.wr_op)
            WR_HIT: begin
                wr_addr        = hit_idx_reg;
                wr_data.busy   = 1'b1;
                wr_data.length = req_size_reg;
                wr_data.start  = hit_start_reg;
            end
            WR_SPLIT: begin
                wr_addr        = count_reg[IDX_W-1:0];
                wr_data.busy   = 1'b0;
                wr_data.length = hit_len_reg - req_size_reg;
                wr_data.start  = hit_start_reg + req_size_reg;
            end
            WR_FREE: begin
                wr_addr        = hit_idx_reg;
                wr_data.busy   = 1'b0;
                wr_data.length = hit_len_reg;
                wr_data.start  = hit_start_reg;
            end
            WR_BUMP: begin
                wr_addr        = count_reg[IDX_W-1:0];
                wr_data.busy   = 1'b1;
                wr_data.length = req_size_reg;
                wr_data.start  = bump_reg;
            end
            default: begin
                wr_addr = hit_idx_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_idx_reg[IDX_W-1:0]];
    end

    // heap bound, capped at the top of the address space
    assign limit_sum = {1'b0, heap_base_reg} + {1'b0, heap_size_reg};
    assign limit_cap = limit_sum[DATA_W] ? {1'b1, {DATA_W{1'b0}}} : limit_sum;
    assign bump_end  = {1'b0, bump_reg} + {1'b0, req_size_reg};

    // result
    always_comb begin
        unique case (cmd.res_sel)
            RES_HIT:  res_addr_next = hit_start_reg;
            RES_BUMP: res_addr_next = bump_reg;
            default:  res_addr_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.res_load) begin
            res_status_reg <= cmd.res_status;
            res_addr_reg   <= res_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_addr_reg   <= res_addr_reg;
            m_status_reg <= res_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_addr_reg;
    assign m_tuser  = m_status_reg;

    assign sts.is_free    = (req_cmd_reg == CMD_FREE);
    assign sts.size_zero  = (req_size_reg == '0);
    assign sts.table_full = (count_reg >= CNT_W'(TABLE_DEPTH - 1));
    assign sts.count_zero = (count_reg == '0);
    assign sts.hit        = hit;
    assign sts.miss       = rd_valid_reg && !hit && last_entry;
    assign sts.fits       = (bump_end <= limit_cap);
    assign sts.spare_nz   = (hit_len_reg != req_size_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

endmodule

[rtl/core/first_fit_block_allocator_core.sv]
// top level of the first-fit block allocator
// joins ffba_ctrl and ffba_dp; depends on ffba_pkg
//
// channel  dir  handshake           contents
// s_       in   s_tvalid/s_tready   allocate or free request
// m_       out  m_tvalid/m_tready   granted address and status
// cfg_     in   cfg_valid/cfg_ready heap_base (0), heap_size (1)
//
// request handling: the scan reads one table entry per cycle and compares the registered read;
// a hit with split takes up to two write-backs. zero size, full table or free on an empty table
// skip the scan and go straight to done, and a bump on an empty table passes through the bump state.
// reset clears control state, entry count and bump pointer; the table needs no clearing.
// a finished result waits in the output register; the next request is taken meanwhile,
// and its result holds the controller in done until that register frees.
module first_fit_block_allocator_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [31:0] request_size, [63:32] block_address
    input  logic [ffba_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] command
    input  logic [ffba_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [31:0] granted_address
    output logic [ffba_pkg::M_TDATA_W-1:0]   m_tdata,
    // [1:0] status
    output logic [ffba_pkg::M_TUSER_W-1:0]   m_tuser,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ffba_pkg::DATA_W-1:0]      cfg_data
);
    import ffba_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    assign cfg_ready = 1'b1;

    ffba_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ffba_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

[sim/first_fit_block_allocator_core_tb.sv]
// self-checking bench for first_fit_block_allocator_core: directed table, then random phases
// keeps its own descriptor table, bump pointer and heap bounds to predict every grant
// depends on ffba_pkg and the core rtl
`timescale 1ns / 1ps

module first_fit_block_allocator_core_tb;
    import ffba_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;
    localparam int QUIET_LIMIT  = 4000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 235;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_t;
    typedef enum int { ROW_REQ, ROW_CFG } row_kind_t;

    typedef struct packed {
        logic [DATA_W-1:0] addr;
        logic [1:0]        status;
    } grant_t;

    typedef struct {
        row_kind_t               kind;
        logic                    cmd;
        logic [DATA_W-1:0]       size;
        logic [DATA_W-1:0]       addr;
        logic [CFG_IDX_W-1:0]    idx;
        bit                      typed;
        grant_t                  want;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic [M_TUSER_W-1:0]   m_tuser;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [DATA_W-1:0]      cfg_data  = '0;

    // predicted allocator state
    logic [DATA_W-1:0] tbl_start  [TABLE_DEPTH];
    logic [DATA_W-1:0] tbl_length [TABLE_DEPTH];
    bit                tbl_busy   [TABLE_DEPTH];
    int                tbl_count  = 0;
    logic [DATA_W-1:0] bump_ptr   = '0;
    logic [DATA_W-1:0] heap_lo    = '0;
    logic [DATA_W-1:0] heap_bytes = '0;

    grant_t    outstanding_grants[$];
    stim_row_t directed_rows[$];
    grant_t    want_grant;
    int        fail_count   = 0;
    int        status_seen[4];
    int        reg_writes   = 0;
    int        quiet_cycles = 0;
    int        gap_pct      = 0;
    int        stall_pct    = 0;

    first_fit_block_allocator_core uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void add_entry(input logic [DATA_W-1:0] start,
                                      input logic [DATA_W-1:0] length, input bit busy);
        if (tbl_count < TABLE_DEPTH) begin
            tbl_start[tbl_count]  = start;
            tbl_length[tbl_count] = length;
            tbl_busy[tbl_count]   = busy;
            tbl_count++;
        end
    endfunction

    function automatic grant_t compute_grant(input logic cmd, input logic [DATA_W-1:0] size,
                                             input logic [DATA_W-1:0] addr);
        grant_t      g;
        logic [32:0] bound;
        logic [32:0] stop;
        int          i;
        int          hit;
        g.addr   = '0;
        g.status = ST_OK;
        hit      = -1;
        if (cmd == CMD_FREE) begin
            for (i = 0; i < tbl_count && hit < 0; i++)
                if (tbl_start[i] == addr) hit = i;
            if (hit >= 0) tbl_busy[hit] = 1'b0;
            else g.status = ST_NOT_FOUND;
        end else if (size == '0) begin
            g.status = ST_NO_SPACE;
        end else if (tbl_count != 0 && tbl_count + 2 > TABLE_DEPTH) begin
            g.status = ST_TABLE_FULL;
        end else begin
            for (i = 0; i < tbl_count && hit < 0; i++)
                if (!tbl_busy[i] && tbl_length[i] >= size) hit = i;
            if (hit >= 0) begin
                tbl_busy[hit] = 1'b1;
                if (tbl_length[hit] != size) begin
                    add_entry(tbl_start[hit] + size, tbl_length[hit] - size, 1'b0);
                    tbl_length[hit] = size;
                end
                g.addr = tbl_start[hit];
            end else begin
                bound = {1'b0, heap_lo} + {1'b0, heap_bytes};
                if (bound > 33'h1_0000_0000) bound = 33'h1_0000_0000;
                stop = {1'b0, bump_ptr} + {1'b0, size};
                if (stop > bound) begin
                    g.status = ST_NO_SPACE;
                end else begin
                    add_entry(bump_ptr, size, 1'b1);
                    g.addr   = bump_ptr;
                    bump_ptr = stop[DATA_W-1:0];
                end
            end
        end
        return g;
    endfunction

    function automatic void set_idling(input idle_mode_t mode);
        gap_pct   = (mode == IDLE_SEND) ? 63 : (mode == IDLE_BOTH) ? 8 : 0;
        stall_pct = (mode == IDLE_RECV) ? 63 : (mode == IDLE_BOTH) ? 8 : 0;
    endfunction

    function automatic void add_req(input logic cmd, input logic [DATA_W-1:0] size,
                                    input logic [DATA_W-1:0] addr, input bit typed,
                                    input logic [DATA_W-1:0] want_addr,
                                    input logic [1:0] want_status);
        stim_row_t r;
        r.kind        = ROW_REQ;
        r.cmd         = cmd;
        r.size        = size;
        r.addr        = addr;
        r.idx         = '0;
        r.typed       = typed;
        r.want.addr   = want_addr;
        r.want.status = want_status;
        directed_rows.push_back(r);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [DATA_W-1:0] val);
        stim_row_t r;
        r.kind  = ROW_CFG;
        r.cmd   = CMD_ALLOC;
        r.size  = val;
        r.addr  = '0;
        r.idx   = idx;
        r.typed = 1'b0;
        r.want  = '0;
        directed_rows.push_back(r);
    endfunction

    task automatic send_request(input logic cmd, input logic [DATA_W-1:0] size,
                                input logic [DATA_W-1:0] addr, input bit typed,
                                input grant_t typed_grant);
        grant_t g;
        cfg_valid <= 1'b0;
        if ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < gap_pct);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {addr, size};
        do @(posedge aclk); while (!s_tready);
        g = compute_grant(cmd, size, addr);
        outstanding_grants.push_back(typed ? typed_grant : g);
    endtask

    task automatic drain_grants();
        s_tvalid <= 1'b0;
        while (outstanding_grants.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        drain_grants();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_HEAP_BASE) begin
            heap_lo  = val;
            bump_ptr = val;
        end else if (idx == REG_HEAP_SIZE) begin
            heap_bytes = val;
        end
        reg_writes++;
    endtask

    always @(posedge aclk) m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            status_seen[m_tuser]++;
            if (outstanding_grants.size() == 0) begin
                $display("%0t: result with nothing pending: addr %h status %0d",
                         $time, m_tdata, m_tuser);
                fail_count++;
            end else begin
                want_grant = outstanding_grants.pop_front();
                if (m_tdata !== want_grant.addr) begin
                    $display("%0t: granted_address expected %h actual %h",
                             $time, want_grant.addr, m_tdata);
                    fail_count++;
                end
                if (m_tuser !== want_grant.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want_grant.status, m_tuser);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d requests pending",
                     $time, QUIET_LIMIT, outstanding_grants.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        logic [DATA_W-1:0] ph_base [PHASE_COUNT];
        logic [DATA_W-1:0] ph_size [PHASE_COUNT];
        idle_mode_t        ph_mode [PHASE_COUNT];
        int                ph_grow [PHASE_COUNT];
        stim_row_t         row;
        logic              cmd;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
        int                p;
        int                n;
        int                i;
        int                k;
        int                pick;
        int                roll;

        ph_base = '{32'h0000_0000, 32'h8000_0000, 32'h0, 32'hFFFF_0000, $urandom, 32'h0};
        ph_size = '{32'h0001_0000, 32'h0000_4000, 32'h0, 32'hFFFF_FFFF,
                    $urandom_range(32'h0010_0000, 32'h100), 32'hFFFF_FFFF};
        ph_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_SEND, IDLE_RECV};
        ph_grow = '{3, 3, 4, 3, 4, 25};
        for (i = 0; i < 4; i++) status_seen[i] = 0;

        add_req(CMD_ALLOC, 32'h0, 32'h0, 1, 32'h0, ST_NO_SPACE);
        add_req(CMD_ALLOC, 32'h1, 32'h0, 1, 32'h0, ST_NO_SPACE);
        add_req(CMD_FREE, 32'h0, 32'h0, 1, 32'h0, ST_NOT_FOUND);
        add_cfg(REG_HEAP_BASE, 32'h0000_1000);
        add_cfg(REG_HEAP_SIZE, 32'h0000_0100);
        add_req(CMD_ALLOC, 32'h10, 32'hFFFF_FFFF, 1, 32'h1000, ST_OK);
        add_req(CMD_ALLOC, 32'h20, 32'h0, 1, 32'h1010, ST_OK);
        add_req(CMD_ALLOC, 32'hD0, 32'h0, 1, 32'h1030, ST_OK);
        add_req(CMD_ALLOC, 32'h1, 32'h0, 1, 32'h0, ST_NO_SPACE);
        add_req(CMD_FREE, 32'hFFFF_FFFF, 32'h1010, 1, 32'h0, ST_OK);
        add_req(CMD_FREE, 32'h0, 32'h1010, 1, 32'h0, ST_OK);
        add_req(CMD_FREE, 32'h0, 32'h1011, 1, 32'h0, ST_NOT_FOUND);
        add_req(CMD_ALLOC, 32'h20, 32'h0, 1, 32'h1010, ST_OK);
        add_req(CMD_FREE, 32'h0, 32'h1030, 0, 32'h0, ST_OK);
        add_req(CMD_ALLOC, 32'h50, 32'h0, 0, 32'h0, ST_OK);
        add_req(CMD_ALLOC, 32'h80, 32'h0, 0, 32'h0, ST_OK);
        add_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, 1, 32'h0, ST_NO_SPACE);
        add_req(CMD_FREE, 32'h0, 32'hFFFF_FFFF, 1, 32'h0, ST_NOT_FOUND);
        add_cfg(REG_SPARE_LO, 32'h5555_5555);
        add_cfg(REG_SPARE_HI, 32'hAAAA_AAAA);
        add_req(CMD_ALLOC, 32'h1, 32'h0, 1, 32'h0, ST_NO_SPACE);
        add_cfg(REG_HEAP_BASE, 32'hFFFF_FFF0);
        add_cfg(REG_HEAP_SIZE, 32'hFFFF_FFFF);
        add_req(CMD_ALLOC, 32'h10, 32'h0, 0, 32'h0, ST_OK);
        add_req(CMD_ALLOC, 32'h20, 32'h0, 0, 32'h0, ST_OK);
        add_req(CMD_ALLOC, 32'hFFFF_FFFF, 32'h0, 0, 32'h0, ST_OK);
        add_req(CMD_FREE, 32'h0, 32'h0, 0, 32'h0, ST_OK);
        add_cfg(REG_HEAP_BASE, 32'hFFFF_FFFF);
        add_cfg(REG_HEAP_SIZE, 32'h0);
        add_req(CMD_ALLOC, 32'h2, 32'h0, 0, 32'h0, ST_OK);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_idling(IDLE_NONE);
        foreach (directed_rows[j]) begin
            row = directed_rows[j];
            if (row.kind == ROW_CFG)
                write_reg(row.idx, row.size);
            else
                send_request(row.cmd, row.size, row.addr, row.typed, row.want);
        end

        for (p = 0; p < PHASE_COUNT; p++) begin
            if (p != 2) write_reg(REG_HEAP_BASE, ph_base[p]);
            write_reg(REG_HEAP_SIZE, ph_size[p]);
            set_idling(ph_mode[p]);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                cmd  = CMD_ALLOC;
                size = $urandom;
                addr = $urandom;
                pick = -1;
                roll = $urandom_range(99);
                if (roll < ph_grow[p]) begin
                    // new entry: split a free block or take fresh heap
                    k = $urandom_range(TABLE_DEPTH - 1);
                    for (i = 0; i < tbl_count && pick < 0; i++)
                        if (!tbl_busy[(i + k) % tbl_count]) pick = (i + k) % tbl_count;
                    if (pick >= 0 && $urandom_range(1) == 1)
                        size = $urandom_range(tbl_length[pick], 1);
                    else
                        size = $urandom_range(256, 1);
                end else begin
                    roll = $urandom_range(99);
                    if (roll >= 50 && roll < 88) begin
                        // exact fit on the first free entry keeps the table from growing
                        for (i = 0; i < tbl_count && pick < 0; i++)
                            if (!tbl_busy[i]) pick = i;
                        if (pick >= 0) size = tbl_length[pick];
                        else roll = 0;
                    end
                    if (roll < 45 && tbl_count > 0) begin
                        cmd  = CMD_FREE;
                        addr = tbl_start[$urandom_range(tbl_count - 1)];
                    end else if (roll < 50) begin
                        cmd = CMD_FREE;
                    end else if (roll >= 88 && roll < 91) begin
                        size = '0;
                    end
                end
                send_request(cmd, size, addr, 0, '0);
                if ($urandom_range(199) == 0) drain_grants();
            end
        end

        drain_grants();
        repeat (2 * TABLE_DEPTH) @(posedge aclk);
        $display("%0d results: %0d ok, %0d no space or zero size, %0d table full, %0d unknown",
                 status_seen[0] + status_seen[1] + status_seen[2] + status_seen[3],
                 status_seen[ST_OK], status_seen[ST_NO_SPACE], status_seen[ST_TABLE_FULL],
                 status_seen[ST_NOT_FOUND]);
        $display("%0d register writes, %0d of %0d descriptors in use at the end",
                 reg_writes, tbl_count, TABLE_DEPTH);
        if (fail_count == 0 && outstanding_grants.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
